// ===== rtl/nearest_pitch_range_finder_top_defines.svh =====
// Assertion macros shared by the checker.
`ifndef NEAREST_PITCH_RANGE_FINDER_TOP_DEFINES_SVH
`define NEAREST_PITCH_RANGE_FINDER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the block clock, off while in reset.
`define NPRF_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define NPRF_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/nprf_pkg.sv =====
package nprf_pkg;

   localparam int VAL_W              = 16;  // Q4.12 pitch and bounds
   localparam int FIELD_IDX_W        = 4;   // index fields on the ports
   localparam int COUNT_REG_W        = 5;   // range_count register
   localparam int PROD_W             = 2 * VAL_W;
   localparam int MAX_RANGES_DEFAULT = 16;

   // req_mode codes
   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   typedef struct packed {
      logic             has_variants;
      logic [VAL_W-1:0] lower;
      logic [VAL_W-1:0] upper;
   } entry_type;

endpackage

// ===== rtl/nprf_table.sv =====
module nprf_table #(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  nprf_pkg::entry_type wr_data,
   input  logic [ADDR_W-1:0]   rd_addr,
   output nprf_pkg::entry_type rd_data
);
   import nprf_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read, one address per cycle
   always_ff @(posedge clock) begin
      rd_ff <= mem[rd_addr];
   end

   assign rd_data = rd_ff;

endmodule

// ===== rtl/nprf_xmul.sv =====
module nprf_xmul (
   input  logic                       clock,
   input  logic                       load,
   input  logic [nprf_pkg::VAL_W-1:0] a_num,
   input  logic [nprf_pkg::VAL_W-1:0] a_den,
   input  logic [nprf_pkg::VAL_W-1:0] b_num,
   input  logic [nprf_pkg::VAL_W-1:0] b_den,
   output logic                       a_lt_b
);
   import nprf_pkg::*;

   // a_num/a_den < b_num/b_den  <=>  a_num*b_den < b_num*a_den
   logic [PROD_W-1:0] prod_a_ff;
   logic [PROD_W-1:0] prod_b_ff;

   always_ff @(posedge clock) begin
      if (load) begin
         prod_a_ff <= PROD_W'(a_num) * PROD_W'(b_den);
         prod_b_ff <= PROD_W'(b_num) * PROD_W'(a_den);
      end
   end

   assign a_lt_b = prod_a_ff < prod_b_ff;

endmodule

// ===== rtl/nearest_pitch_range_finder_top.sv =====
// Nearest pitch range finder. A table of up to MAX_RANGES entries holds a
// lower and an upper bound (unsigned Q4.12) and a has_variants flag; an entry
// without the flag is empty. An item is taken when start is high and busy is
// low. A load item (req_mode 0) writes entry req_entry_index,
// keeps busy low and gives no result; an index at or above MAX_RANGES is
// dropped. A query item (req_mode 1) raises busy and gives exactly one result:
// rsp_strobe is high for a single cycle with rsp_found and rsp_range_index,
// and there is no way to hold it off, so the receiver must take it then.
// The hinted entry wins if it is in range and contains the pitch; otherwise
// the first non-empty entry containing the pitch; otherwise the non-empty
// entry nearest in ratio (pitch/upper above the range, lower/pitch below),
// earliest on a tie. rsp_range_index is zero when nothing is found.
// A query first checks the hinted entry (S_HINT) and answers from there on a
// hit, or when range_count is zero. Otherwise it reads the entries in order
// through the single table read port (up to range_count, stopping at the
// first hit); a non-empty entry that misses the pitch and has a nonzero
// denominator is scored by the shared cross multiplier (S_EVAL) and then
// compared to the best (S_CMP). A new item may be started in the cycle the
// strobe is shown. csr_wr_data sets range_count (values above MAX_RANGES act
// as MAX_RANGES); write it only while no query is in flight. Table entries
// must be written before a query reads them.
module nearest_pitch_range_finder_top #(
   parameter int MAX_RANGES = nprf_pkg::MAX_RANGES_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // command channel
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_mode,
   input  logic [nprf_pkg::FIELD_IDX_W-1:0] req_entry_index,
   input  logic [nprf_pkg::VAL_W-1:0]       req_lower_bound,
   input  logic [nprf_pkg::VAL_W-1:0]       req_upper_bound,
   input  logic                             req_has_variants,
   input  logic [nprf_pkg::VAL_W-1:0]       req_pitch,
   input  logic                             req_hint_valid,
   input  logic [nprf_pkg::FIELD_IDX_W-1:0] req_hint_index,
   // result channel
   output logic                             rsp_strobe,
   output logic                             rsp_found,
   output logic [nprf_pkg::FIELD_IDX_W-1:0] rsp_range_index,
   // range_count register
   input  logic                             csr_wr_en,
   input  logic [nprf_pkg::COUNT_REG_W-1:0] csr_wr_data
);
   import nprf_pkg::*;

   localparam int IDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
   localparam int CNT_W = $clog2(MAX_RANGES + 1);
   localparam int CMP_W = (CNT_W > COUNT_REG_W) ? CNT_W : COUNT_REG_W;
   localparam logic [CMP_W-1:0] MAX_EXT = CMP_W'(MAX_RANGES);

   typedef enum logic [1:0] {
      S_IDLE,
      S_HINT,   // hinted entry on the read port
      S_EVAL,   // entry cur_ff on the read port, products launched
      S_CMP     // products ready, update the best candidate
   } state_type;

   state_type             state_ff, state_in;
   logic [COUNT_REG_W-1:0] range_count_ff;
   logic [VAL_W-1:0]       pitch_ff, pitch_in;
   logic                   hint_ok_ff, hint_ok_in;
   logic [FIELD_IDX_W-1:0] hint_ff, hint_in;
   logic [IDX_W-1:0]       addr_ff, addr_in;
   logic [CNT_W-1:0]       cur_ff, cur_in;
   logic                   have_ff, have_in;
   logic [CNT_W-1:0]       best_idx_ff, best_idx_in;
   logic [VAL_W-1:0]       best_num_ff, best_num_in;
   logic [VAL_W-1:0]       best_den_ff, best_den_in;
   logic [VAL_W-1:0]       cand_num_ff, cand_num_in;
   logic [VAL_W-1:0]       cand_den_ff, cand_den_in;
   logic                   rsp_strobe_ff, rsp_strobe_in;
   logic                   rsp_found_ff, rsp_found_in;
   logic [FIELD_IDX_W-1:0] rsp_index_ff, rsp_index_in;

   logic [CMP_W-1:0]       rc_ext;
   logic [CNT_W-1:0]       cnt_eff;
   logic                   accept;
   logic                   tbl_wr_en;
   entry_type              tbl_wr_data;
   logic [IDX_W-1:0]       tbl_rd_addr;
   entry_type              rd;
   logic                   contains;
   logic                   above;
   logic [VAL_W-1:0]       num;
   logic [VAL_W-1:0]       den;
   logic                   candidate;
   logic                   xmul_load;
   logic                   cand_lt_best;
   logic [CNT_W-1:0]       cur_next;
   logic                   last;
   logic                   take;

   // effective count, clamped to the table size
   assign rc_ext  = CMP_W'(range_count_ff);
   assign cnt_eff = CNT_W'((rc_ext > MAX_EXT) ? MAX_EXT : rc_ext);

   assign accept = start && (state_ff == S_IDLE);
   assign busy   = (state_ff != S_IDLE);

   assign tbl_wr_en = accept && (req_mode == MODE_LOAD)
                      && (CMP_W'(req_entry_index) < MAX_EXT);
   assign tbl_wr_data.has_variants = req_has_variants;
   assign tbl_wr_data.lower        = req_lower_bound;
   assign tbl_wr_data.upper        = req_upper_bound;

   // hint is read at the accept edge; the scan address runs one ahead
   assign tbl_rd_addr = (state_ff == S_IDLE) ? IDX_W'(req_hint_index) : addr_ff;

   nprf_table #(
      .DEPTH  (MAX_RANGES),
      .ADDR_W (IDX_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (IDX_W'(req_entry_index)),
      .wr_data (tbl_wr_data),
      .rd_addr (tbl_rd_addr),
      .rd_data (rd)
   );

   // entry on the read port against the latched pitch
   assign contains  = rd.has_variants && (rd.lower <= pitch_ff) && (pitch_ff <= rd.upper);
   assign above     = rd.upper < pitch_ff;
   assign num       = above ? pitch_ff : rd.lower;
   assign den       = above ? rd.upper : pitch_ff;
   assign candidate = rd.has_variants && (den != '0);   // zero den: infinite ratio
   assign xmul_load = (state_ff == S_EVAL) && candidate;

   nprf_xmul u_xmul (
      .clock  (clock),
      .load   (xmul_load),
      .a_num  (num),
      .a_den  (den),
      .b_num  (best_num_ff),
      .b_den  (best_den_ff),
      .a_lt_b (cand_lt_best)
   );

   assign cur_next = cur_ff + CNT_W'(1);
   assign last     = (cur_next == cnt_eff);
   assign take     = !have_ff || cand_lt_best;   // strict: earliest wins a tie

   always_comb begin
      state_in      = state_ff;
      pitch_in      = pitch_ff;
      hint_ok_in    = hint_ok_ff;
      hint_in       = hint_ff;
      addr_in       = addr_ff;
      cur_in        = cur_ff;
      have_in       = have_ff;
      best_idx_in   = best_idx_ff;
      best_num_in   = best_num_ff;
      best_den_in   = best_den_ff;
      cand_num_in   = cand_num_ff;
      cand_den_in   = cand_den_ff;
      rsp_strobe_in = 1'b0;
      rsp_found_in  = rsp_found_ff;
      rsp_index_in  = rsp_index_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept && (req_mode == MODE_QUERY)) begin
               state_in    = S_HINT;
               pitch_in    = req_pitch;
               hint_in     = req_hint_index;
               hint_ok_in  = req_hint_valid
                             && (CMP_W'(req_hint_index) < CMP_W'(cnt_eff));
               addr_in     = '0;
               have_in     = 1'b0;
               best_idx_in = '0;
               best_num_in = '0;
               best_den_in = VAL_W'(1);
            end
         end
         S_HINT: begin
            if (hint_ok_ff && contains) begin
               state_in      = S_IDLE;
               rsp_strobe_in = 1'b1;
               rsp_found_in  = 1'b1;
               rsp_index_in  = hint_ff;
            end else if (cnt_eff == '0) begin
               state_in      = S_IDLE;
               rsp_strobe_in = 1'b1;
               rsp_found_in  = 1'b0;
               rsp_index_in  = '0;
            end else begin
               state_in = S_EVAL;
               cur_in   = '0;
               addr_in  = IDX_W'(1);
            end
         end
         S_EVAL: begin
            if (contains) begin
               state_in      = S_IDLE;
               rsp_strobe_in = 1'b1;
               rsp_found_in  = 1'b1;
               rsp_index_in  = FIELD_IDX_W'(cur_ff);
            end else if (candidate) begin
               // hold addr_ff: the next entry is read again during compare
               state_in    = S_CMP;
               cand_num_in = num;
               cand_den_in = den;
            end else if (last) begin
               state_in      = S_IDLE;
               rsp_strobe_in = 1'b1;
               rsp_found_in  = have_ff;
               rsp_index_in  = have_ff ? FIELD_IDX_W'(best_idx_ff) : '0;
            end else begin
               cur_in  = cur_next;
               addr_in = addr_ff + IDX_W'(1);
            end
         end
         S_CMP: begin
            if (take) begin
               have_in     = 1'b1;
               best_idx_in = cur_ff;
               best_num_in = cand_num_ff;
               best_den_in = cand_den_ff;
            end
            if (last) begin
               state_in      = S_IDLE;
               rsp_strobe_in = 1'b1;
               rsp_found_in  = 1'b1;
               rsp_index_in  = take ? FIELD_IDX_W'(cur_ff) : FIELD_IDX_W'(best_idx_ff);
            end else begin
               state_in = S_EVAL;
               cur_in   = cur_next;
               addr_in  = addr_ff + IDX_W'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         range_count_ff <= '0;
         rsp_strobe_ff  <= 1'b0;
         rsp_found_ff   <= 1'b0;
         rsp_index_ff   <= '0;
         have_ff        <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         rsp_found_ff  <= rsp_found_in;
         rsp_index_ff  <= rsp_index_in;
         have_ff       <= have_in;
         if (csr_wr_en) begin
            range_count_ff <= csr_wr_data;
         end
      end
      pitch_ff    <= pitch_in;
      hint_ok_ff  <= hint_ok_in;
      hint_ff     <= hint_in;
      addr_ff     <= addr_in;
      cur_ff      <= cur_in;
      best_idx_ff <= best_idx_in;
      best_num_ff <= best_num_in;
      best_den_ff <= best_den_in;
      cand_num_ff <= cand_num_in;
      cand_den_ff <= cand_den_in;
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_range_index = rsp_index_ff;

endmodule

// ===== rtl/nprf_checker.sv =====
`include "nearest_pitch_range_finder_top_defines.svh"

module nprf_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             start,
   input logic                             busy,
   input logic                             req_mode,
   input logic                             rsp_strobe,
   input logic                             rsp_found,
   input logic [nprf_pkg::FIELD_IDX_W-1:0] rsp_range_index
);
   import nprf_pkg::*;

   logic take_query;
   logic take_load;
   logic miss_shown;

   assign take_query = start && !busy && (req_mode == MODE_QUERY);
   assign take_load  = start && !busy && (req_mode == MODE_LOAD);
   assign miss_shown = rsp_strobe && !rsp_found;

   // a miss reports index zero
   `NPRF_ASSERT_NOW(a_miss_zero, miss_shown, rsp_range_index == '0, "miss with nonzero index")

   // a query raises busy in the cycle after it is taken
   `NPRF_ASSERT_NEXT(a_query_busy, take_query, busy, "query did not raise busy")

   // a load leaves busy low and gives no item
   `NPRF_ASSERT_NEXT(a_load_quiet, take_load, !busy && !rsp_strobe, "load not quiet")

   // every item closes a busy period
   `NPRF_ASSERT_NOW(a_rsp_after_busy, rsp_strobe, $past(busy), "item without a query in flight")

   // items are never back to back
   `NPRF_ASSERT_NEXT(a_rsp_single, rsp_strobe, !rsp_strobe, "strobe held for two cycles")

endmodule

bind nearest_pitch_range_finder_top nprf_checker u_nprf_checker (.*);

// ===== tb/nprf_choice_monitor.sv =====
package nprf_tb_pkg;

   typedef enum logic {
      MODE_LOAD  = 1'b0,
      MODE_QUERY = 1'b1
   } req_mode_type;

endpackage

module nprf_choice_monitor #(
   parameter int MAX_RANGES = nprf_pkg::MAX_RANGES_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic                             busy,
   input  logic                             req_mode,
   input  logic [nprf_pkg::FIELD_IDX_W-1:0] req_entry_index,
   input  logic [nprf_pkg::VAL_W-1:0]       req_lower_bound,
   input  logic [nprf_pkg::VAL_W-1:0]       req_upper_bound,
   input  logic                             req_has_variants,
   input  logic [nprf_pkg::VAL_W-1:0]       req_pitch,
   input  logic                             req_hint_valid,
   input  logic [nprf_pkg::FIELD_IDX_W-1:0] req_hint_index,
   input  logic                             rsp_strobe,
   input  logic                             rsp_found,
   input  logic [nprf_pkg::FIELD_IDX_W-1:0] rsp_range_index,
   input  logic                             csr_wr_en,
   input  logic [nprf_pkg::COUNT_REG_W-1:0] csr_wr_data,
   output int                               mismatches,
   output int                               results_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PW = nprf_pkg::PROD_W;

   typedef struct packed {
      logic                             found;
      logic [nprf_pkg::FIELD_IDX_W-1:0] index;
   } range_choice_type;

   nprf_pkg::entry_type              pitch_table [MAX_RANGES];
   logic [nprf_pkg::COUNT_REG_W-1:0] range_count;
   range_choice_type                 expected_choice_q [$];

   function automatic logic covers(input int unsigned i, input logic [nprf_pkg::VAL_W-1:0] p);
      return pitch_table[i].has_variants && pitch_table[i].lower <= p &&
             p <= pitch_table[i].upper;
   endfunction

   // hint first, then first containing entry, then smallest ratio (earliest on tie)
   function automatic range_choice_type nearest_range_lookup(
      input logic [nprf_pkg::VAL_W-1:0]       p,
      input logic                             hint_ok,
      input logic [nprf_pkg::FIELD_IDX_W-1:0] hint
   );
      range_choice_type              pick;
      int unsigned                   lim;
      logic                          have;
      logic                          hit;
      logic [nprf_pkg::VAL_W-1:0]    num, den, best_num, best_den;
      logic [nprf_pkg::PROD_W-1:0]   lhs, rhs;
      lim      = (range_count > MAX_RANGES) ? MAX_RANGES : range_count;
      pick     = '0;
      have     = 1'b0;
      hit      = 1'b0;
      best_num = '0;
      best_den = 16'd1;
      if (hint_ok && hint < lim && covers(hint, p)) begin
         pick.found = 1'b1;
         pick.index = hint;
         hit        = 1'b1;
      end
      for (int i = 0; i < lim && !hit; i++) begin
         if (pitch_table[i].has_variants) begin
            if (covers(i, p)) begin
               pick.found = 1'b1;
               pick.index = 4'(i);
               hit        = 1'b1;
            end else begin
               if (pitch_table[i].upper < p) begin
                  num = p;
                  den = pitch_table[i].upper;
               end else begin
                  num = pitch_table[i].lower;
                  den = p;
               end
               lhs = PW'(num) * PW'(best_den);
               rhs = PW'(best_num) * PW'(den);
               // zero denominator means an infinite ratio
               if (den != 0 && (!have || lhs < rhs)) begin
                  have       = 1'b1;
                  pick.index = 4'(i);
                  best_num   = num;
                  best_den   = den;
               end
            end
         end
      end
      if (!hit) begin
         pick.found = have;
      end
      return pick;
   endfunction

   task automatic flag_mismatch(input string what, input int got, input int want);
      mismatches++;
      $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   always @(posedge clock) begin : watch
      range_choice_type want;
      if (reset) begin
         expected_choice_q.delete();
         range_count = '0;
         mismatches  = 0;
      end else begin
         if (rsp_strobe) begin
            if (expected_choice_q.size() == 0) begin
               flag_mismatch("result item with no query outstanding", rsp_range_index, -1);
            end else begin
               want = expected_choice_q.pop_front();
               if (rsp_found !== want.found) begin
                  flag_mismatch("rsp_found", rsp_found, want.found);
               end
               if (rsp_range_index !== want.index) begin
                  flag_mismatch("rsp_range_index", rsp_range_index, want.index);
               end
            end
         end
         if (csr_wr_en) begin
            range_count = csr_wr_data;
         end
         if (start && !busy) begin
            if (req_mode == nprf_tb_pkg::MODE_QUERY) begin
               expected_choice_q.push_back(
                  nearest_range_lookup(req_pitch, req_hint_valid, req_hint_index));
            end else if (req_entry_index < MAX_RANGES) begin
               pitch_table[req_entry_index].has_variants = req_has_variants;
               pitch_table[req_entry_index].lower        = req_lower_bound;
               pitch_table[req_entry_index].upper        = req_upper_bound;
            end
         end
      end
      results_pending <= expected_choice_q.size();
   end

endmodule

// ===== tb/tb_nearest_pitch_range_finder_top.sv =====
module tb_nearest_pitch_range_finder_top;
   timeunit 1ns;
   timeprecision 1ps;

   import nprf_tb_pkg::*;

   localparam int VW = nprf_pkg::VAL_W;
   localparam int IW = nprf_pkg::FIELD_IDX_W;
   localparam int CW = nprf_pkg::COUNT_REG_W;
   localparam int N_ENTRIES = nprf_pkg::MAX_RANGES_DEFAULT;
   // margin over a full 16-entry scan with every entry scored
   localparam int DRAIN_CYCLES = 40;

   // one command item as the sender sees it
   typedef struct {
      req_mode_type  mode;
      logic [IW-1:0] entry_index;
      logic [VW-1:0] lower;
      logic [VW-1:0] upper;
      logic          has_variants;
      logic [VW-1:0] pitch;
      logic          hint_valid;
      logic [IW-1:0] hint_index;
   } pitch_cmd_type;

   logic          clock;
   logic          reset;
   logic          start;
   logic          busy;
   logic          req_mode;
   logic [IW-1:0] req_entry_index;
   logic [VW-1:0] req_lower_bound;
   logic [VW-1:0] req_upper_bound;
   logic          req_has_variants;
   logic [VW-1:0] req_pitch;
   logic          req_hint_valid;
   logic [IW-1:0] req_hint_index;
   logic          rsp_strobe;
   logic          rsp_found;
   logic [IW-1:0] rsp_range_index;
   logic          csr_wr_en;
   logic [CW-1:0] csr_wr_data;
   int            mismatches;
   int            results_pending;

   // bounds as loaded, used to aim query pitches at or near real entries and to draw duplicates
   logic [VW-1:0] lower_seen [N_ENTRIES];
   logic [VW-1:0] upper_seen [N_ENTRIES];

   nearest_pitch_range_finder_top dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_mode         (req_mode),
      .req_entry_index  (req_entry_index),
      .req_lower_bound  (req_lower_bound),
      .req_upper_bound  (req_upper_bound),
      .req_has_variants (req_has_variants),
      .req_pitch        (req_pitch),
      .req_hint_valid   (req_hint_valid),
      .req_hint_index   (req_hint_index),
      .rsp_strobe       (rsp_strobe),
      .rsp_found        (rsp_found),
      .rsp_range_index  (rsp_range_index),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   // predicts and compares every result item; hands back the failure count
   nprf_choice_monitor monitor (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_mode         (req_mode),
      .req_entry_index  (req_entry_index),
      .req_lower_bound  (req_lower_bound),
      .req_upper_bound  (req_upper_bound),
      .req_has_variants (req_has_variants),
      .req_pitch        (req_pitch),
      .req_hint_valid   (req_hint_valid),
      .req_hint_index   (req_hint_index),
      .rsp_strobe       (rsp_strobe),
      .rsp_found        (rsp_found),
      .rsp_range_index  (rsp_range_index),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .mismatches       (mismatches),
      .results_pending  (results_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog: ends the run with FAIL if it has not finished
   initial begin
      #5_000_000;
      $display("tb_nearest_pitch_range_finder_top: FAIL");
      $finish;
   end

   // Present one item and hold it until the block takes it. Start is left high
   // after the accept edge; the next call either overwrites the fields or drops
   // start for a gap, so start never gets two assignments in one step.
   task automatic send_cmd(input pitch_cmd_type c, input int idle_pct);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      start            <= 1'b1;
      req_mode         <= c.mode;
      req_entry_index  <= c.entry_index;
      req_lower_bound  <= c.lower;
      req_upper_bound  <= c.upper;
      req_has_variants <= c.has_variants;
      req_pitch        <= c.pitch;
      req_hint_valid   <= c.hint_valid;
      req_hint_index   <= c.hint_index;
      // busy read right after the edge is the value the block sampled
      do @(posedge clock); while (busy);
      if (c.mode == MODE_LOAD) begin
         lower_seen[c.entry_index] = c.lower;
         upper_seen[c.entry_index] = c.upper;
      end
   endtask

   // drop start, let every outstanding result come back, then let the block go quiet
   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // only called after reset or settle(), so no query is in flight
   task automatic write_range_count(input logic [CW-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic load_entry(input logic [IW-1:0] idx, input logic [VW-1:0] lo,
                             input logic [VW-1:0] hi, input logic has_var);
      pitch_cmd_type c;
      c.mode         = MODE_LOAD;
      c.entry_index  = idx;
      c.lower        = lo;
      c.upper        = hi;
      c.has_variants = has_var;
      c.pitch        = 16'hFFFF;
      c.hint_valid   = 1'b1;
      c.hint_index   = ~idx;
      send_cmd(c, 0);
   endtask

   task automatic lookup(input logic [VW-1:0] p, input logic hint_ok, input logic [IW-1:0] hint);
      pitch_cmd_type c;
      c.mode         = MODE_QUERY;
      c.entry_index  = 4'hF;
      c.lower        = 16'hFFFF;
      c.upper        = 16'h0000;
      c.has_variants = 1'b1;
      c.pitch        = p;
      c.hint_valid   = hint_ok;
      c.hint_index   = hint;
      send_cmd(c, 0);
   endtask

   // Random item. Loads are mostly narrow, non-empty ranges, with some
   // inverted, zero-upper and duplicated entries; half of the queries aim inside or
   // at the edge of a real entry (the hinted one when the hint is on).
   function automatic pitch_cmd_type draw_cmd();
      pitch_cmd_type c;
      int unsigned   k;
      int unsigned   lo;
      c.mode         = ($urandom_range(99) < 25) ? MODE_LOAD : MODE_QUERY;
      c.entry_index  = IW'($urandom_range(15));
      c.lower        = VW'($urandom);
      c.upper        = VW'($urandom);
      c.has_variants = ($urandom_range(99) < 80);
      c.pitch        = VW'($urandom);
      c.hint_valid   = ($urandom_range(99) < 60);
      c.hint_index   = IW'($urandom_range(15));
      k = c.hint_valid ? c.hint_index : $urandom_range(15);
      if (c.mode == MODE_LOAD) begin
         case ($urandom_range(9))
            0: ;  // fully random, often inverted
            7: begin
               c.lower = lower_seen[k];
               c.upper = upper_seen[k];
            end
            8: begin
               c.lower = VW'($urandom_range(0, 16'h0FFF));
               c.upper = 16'h0000;
            end
            9: begin
               c.lower = 16'h0001;
               c.upper = 16'hFFFF;
            end
            default: begin
               lo      = $urandom_range(1, 16'hF000);
               c.lower = VW'(lo);
               c.upper = VW'(lo + $urandom_range(0, 16'h0FFF));
            end
         endcase
      end else begin
         case ($urandom_range(9))
            0, 1, 2, 3: c.pitch = VW'($urandom_range(lower_seen[k], upper_seen[k]));
            4:          c.pitch = $urandom_range(1) ? lower_seen[k] : upper_seen[k];
            5: begin
               case ($urandom_range(2))
                  0:       c.pitch = 16'h0000;
                  1:       c.pitch = 16'h0001;
                  default: c.pitch = 16'hFFFF;
               endcase
            end
            default: ;
         endcase
      end
      return c;
   endfunction

   initial begin
      int idle_pct;
      int per_setting;
      logic [CW-1:0] count_value;

      reset            = 1'b1;
      start            = 1'b0;
      req_mode         = MODE_LOAD;
      req_entry_index  = '0;
      req_lower_bound  = '0;
      req_upper_bound  = '0;
      req_has_variants = 1'b0;
      req_pitch        = '0;
      req_hint_valid   = 1'b0;
      req_hint_index   = '0;
      csr_wr_en        = 1'b0;
      csr_wr_data      = '0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed part ----
      // zero count: nothing is scanned, nothing found, hint out of range
      write_range_count(5'd0);
      lookup(16'h1000, 1'b1, 4'd0);

      // fill the whole table before any query can read it
      load_entry(4'd0, 16'h1000, 16'h2000, 1'b1);
      load_entry(4'd1, 16'h0001, 16'hFFFF, 1'b0);   // empty entry covering everything
      load_entry(4'd2, 16'h3000, 16'h2800, 1'b1);   // inverted bounds
      load_entry(4'd3, 16'h4000, 16'h5000, 1'b1);
      load_entry(4'd4, 16'h0800, 16'h0000, 1'b1);   // upper zero
      load_entry(4'd5, 16'h4000, 16'h5000, 1'b1);   // duplicate of 3, ties
      load_entry(4'd6, 16'hFFFF, 16'hFFFF, 1'b1);
      load_entry(4'd7, 16'h0001, 16'h0001, 1'b1);
      for (int i = 8; i < N_ENTRIES; i++) begin
         load_entry(4'(i), 16'(i << 12), 16'((i << 12) | 16'h0800), (i != 10));
      end
      settle();

      write_range_count(5'd16);
      lookup(16'h1800, 1'b1, 4'd3);    // hint misses, scan finds 0
      lookup(16'h4800, 1'b1, 4'd5);    // hint wins over an earlier container
      lookup(16'h4800, 1'b0, 4'd5);    // no hint: earliest container
      lookup(16'h8000, 1'b1, 4'd1);    // hinted entry empty
      lookup(16'h0000, 1'b0, 4'd0);    // zero pitch: every ratio infinite
      lookup(16'hFFFF, 1'b1, 4'd15);   // top of range
      lookup(16'h2C00, 1'b0, 4'd0);    // falls into the inverted entry's gap
      lookup(16'h0400, 1'b1, 4'd2);    // nearest by ratio
      settle();

      write_range_count(5'd31);        // above table size, acts as full
      lookup(16'h5800, 1'b1, 4'd14);
      settle();

      write_range_count(5'd1);
      lookup(16'h4800, 1'b1, 4'd5);    // hint beyond count
      settle();

      // ---- random part: three idle profiles, four count settings each ----
      for (int ph = 0; ph < 3; ph++) begin
         idle_pct = (ph == 0) ? 19 : (ph == 1) ? 49 : 0;
         for (int sub = 0; sub < 4; sub++) begin
            case (sub)
               0:       count_value = 5'd16;
               1:       count_value = 5'($urandom_range(1, 15));
               2:       count_value = (ph == 0) ? 5'd0 : 5'($urandom_range(17, 31));
               default: count_value = (ph == 1) ? 5'd31 : 5'($urandom_range(2, 16));
            endcase
            write_range_count(count_value);
            per_setting = (count_value == 0) ? 30 : 120;
            for (int n = 0; n < per_setting; n++) begin
               send_cmd(draw_cmd(), idle_pct);
            end
            // every count change waits for all results first
            settle();
         end
      end

      if (mismatches == 0 && results_pending == 0) begin
         $display("tb_nearest_pitch_range_finder_top: PASS");
      end else begin
         $display("tb_nearest_pitch_range_finder_top: FAIL");
      end
      $finish;
   end

endmodule
